/* rtl/assert_macros.svh */
// Assertion macros used by the scheduler datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define PAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define PAS_NEVER(lbl, expr, msg) \
  `PAS_ASSERT(lbl, !(expr), msg)

`endif

/* rtl/pas_pkg.sv */
// Types and constants shared by the priority admission scheduler modules.
package pas_pkg;

  localparam int TASK_W     = 16;
  localparam int PRIO_W     = 4;
  localparam int NEED_W     = 4;
  localparam int LIMIT_W    = 6;
  localparam int RUN_W      = 6;
  localparam int TYPE_SLOTS = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;
  localparam int IN_DATA_W  = 48;
  localparam int RESULT_CAP = 16;
  localparam int RES_CNT_W  = 5;

  // Input beat layout inside tdata.
  localparam int IN_PRIO_LSB = 0;
  localparam int IN_NEED_LSB = 4;
  localparam int IN_TASK_LSB = 32;

  // Queue entry layout.
  localparam int PH_W      = 2;
  localparam int PH_LSB    = 0;
  localparam int TASK_LSB  = 2;
  localparam int PRIO_LSB  = 18;
  localparam int NEED_LSB  = 22;

  typedef enum logic [OP_W-1:0] {
    OP_SUBMIT   = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_SCAN     = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_QUEUED     = 3'd0,
    ST_OVER_LIMIT = 3'd1,
    ST_QUEUE_FULL = 3'd2,
    ST_PENDING    = 3'd3,
    ST_DISPATCHED = 3'd4,
    ST_COMPLETED  = 3'd5,
    ST_UNKNOWN    = 3'd6
  } status_e;

  typedef struct packed {
    logic accept;
    logic rd;
    logic eval;
    logic fin;
  } pas_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic ev_push;
    logic fin_push;
    logic out_free;
  } pas_sts_t;

endpackage

/* rtl/pas_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pas_ram #(
  parameter int WIDTH = 50,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pas_ctrl.sv */
// Controller state machine: sequences the queue walk of each accepted beat.
module pas_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pas_pkg::pas_sts_t  sts_i,
  output pas_pkg::pas_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_EVAL,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   rdy_q, rdy_d;

  always_comb begin
    state_d = state_q;
    rdy_d   = rdy_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && rdy_q) begin
          cmd_o.accept = 1'b1;
          rdy_d        = 1'b0;
          state_d      = S_WALK;
        end
      end
      S_WALK: begin
        if (sts_i.walk_done) begin
          state_d = S_FIN;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_EVAL;
        end
      end
      S_EVAL: begin
        // Hold the read entry while an earlier result beat is still waiting.
        if (!(sts_i.ev_push && !sts_i.out_free)) begin
          cmd_o.eval = 1'b1;
          state_d    = S_WALK;
        end
      end
      S_FIN: begin
        if (!(sts_i.fin_push && !sts_i.out_free)) begin
          cmd_o.fin = 1'b1;
          rdy_d     = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        rdy_d   = 1'b1;
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rdy_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      rdy_q   <= rdy_d;
    end
  end

  assign in_ready_o = rdy_q;

endmodule

/* rtl/pas_dp.sv */
// Datapath: queue memory, resource counters, limits and the result register.
`include "assert_macros.svh"

module pas_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_TYPES   = 7
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pas_pkg::pas_cmd_t                 cmd_i,
  output pas_pkg::pas_sts_t                 sts_o,
  input  logic                              cfg_we_i,
  input  logic [pas_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pas_pkg::LIMIT_W-1:0]       cfg_wdata_i,
  input  logic [pas_pkg::OP_W-1:0]          in_op_i,
  input  logic [pas_pkg::IN_DATA_W-1:0]     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pas_pkg::STATUS_W-1:0]      out_status_o,
  output logic [pas_pkg::TASK_W-1:0]        out_task_o,
  output logic                              out_last_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = pas_pkg::NEED_LSB + pas_pkg::NEED_W * NUM_TYPES;
  localparam int IW = pas_pkg::CFG_IDX_W;
  localparam int TW = pas_pkg::TASK_W;
  localparam int NW = pas_pkg::NEED_W;
  localparam int RW = pas_pkg::RUN_W;
  localparam int LW = pas_pkg::LIMIT_W;
  localparam int PW = pas_pkg::PRIO_W;
  localparam int XW = pas_pkg::RES_CNT_W;
  localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
  localparam logic [XW-1:0] RES_CAP_C = XW'(pas_pkg::RESULT_CAP);
  localparam logic [TW-1:0] TASK_MAX  = {TW{1'b1}};

  typedef enum logic [pas_pkg::PH_W-1:0] {
    PH_WAITING    = 2'd0,
    PH_NOTIFIED   = 2'd1,
    PH_DISPATCHED = 2'd2
  } phase_e;

  // Beat being worked on.
  pas_pkg::op_e               op_q;
  logic [pas_pkg::IN_DATA_W-1:0] data_q;

  // Control state.
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [TW-1:0] ntn_q, ntn_d;
  logic [RW-1:0] run_q [NUM_TYPES];
  logic [RW-1:0] run_d [NUM_TYPES];
  logic [LW-1:0] lim_q [NUM_TYPES];
  logic          found_q, found_d;
  logic          stop_q, stop_d;
  logic [XW-1:0] nres_q, nres_d;
  logic          held_v_q, held_v_d;
  logic          out_valid_q;

  // Payload registers.
  pas_pkg::status_e held_st_q;
  logic [TW-1:0]    held_task_q;
  pas_pkg::status_e out_st_q;
  logic [TW-1:0]    out_task_q;
  logic             out_last_q;

  // Decoded fields.
  logic [PW-1:0] in_prio;
  logic [TW-1:0] in_task;
  logic [NW-1:0] in_need [NUM_TYPES];
  logic [EW-1:0] rd_data;
  logic [PW-1:0] rd_prio;
  logic [TW-1:0] rd_task;
  phase_e        rd_phase;
  logic [NW-1:0] rd_need [NUM_TYPES];

  logic          over, full, fits, match;
  logic          sc_disp, sc_note, sc_res;
  logic          out_free;
  logic [CW-1:0] idx_m1, rd_idx;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] new_entry;
  logic [EW-1:0] upd_entry;

  logic             push;
  pas_pkg::status_e push_st;
  logic [TW-1:0]    push_task;
  logic             push_last;

  always_comb begin
    in_prio = data_q[pas_pkg::IN_PRIO_LSB +: PW];
    in_task = data_q[pas_pkg::IN_TASK_LSB +: TW];
    rd_prio = rd_data[pas_pkg::PRIO_LSB +: PW];
    rd_task = rd_data[pas_pkg::TASK_LSB +: TW];
    rd_phase = phase_e'(rd_data[pas_pkg::PH_LSB +: pas_pkg::PH_W]);
    for (int t = 0; t < NUM_TYPES; t++) begin
      in_need[t] = data_q[pas_pkg::IN_NEED_LSB + NW * t +: NW];
      rd_need[t] = rd_data[pas_pkg::NEED_LSB + NW * t +: NW];
    end
  end

  // Limit checks run in parallel over the resource types.
  always_comb begin
    over = 1'b0;
    fits = 1'b1;
    for (int t = 0; t < NUM_TYPES; t++) begin
      if ({2'b00, in_need[t]} > lim_q[t]) begin
        over = 1'b1;
      end
      if (({1'b0, run_q[t]} + {3'b000, rd_need[t]}) > {1'b0, lim_q[t]}) begin
        fits = 1'b0;
      end
    end
  end

  assign full     = (cnt_q >= DEPTH_C);
  assign match    = (rd_phase == PH_DISPATCHED) && (rd_task == in_task);
  assign sc_disp  = (rd_phase != PH_DISPATCHED) && fits;
  assign sc_note  = (rd_phase == PH_WAITING) && !fits;
  assign sc_res   = sc_disp || sc_note;
  assign out_free = !out_valid_q || out_ready_i;
  assign idx_m1   = idx_q - CW'(1);
  assign rd_idx   = (op_q == pas_pkg::OP_SUBMIT) ? idx_m1 : idx_q;

  always_comb begin
    new_entry = '0;
    new_entry[pas_pkg::PH_LSB +: pas_pkg::PH_W] = PH_WAITING;
    new_entry[pas_pkg::TASK_LSB +: TW]          = ntn_q;
    new_entry[pas_pkg::PRIO_LSB +: PW]          = in_prio;
    for (int t = 0; t < NUM_TYPES; t++) begin
      new_entry[pas_pkg::NEED_LSB + NW * t +: NW] = in_need[t];
    end
    upd_entry = rd_data;
    upd_entry[pas_pkg::PH_LSB +: pas_pkg::PH_W] = sc_disp ? PH_DISPATCHED : PH_NOTIFIED;
  end

  // Status toward the controller.
  always_comb begin
    sts_o = '0;
    sts_o.out_free = out_free;
    sts_o.ev_push  = (op_q == pas_pkg::OP_SCAN) && sc_res && held_v_q;
    case (op_q)
      pas_pkg::OP_SUBMIT: begin
        sts_o.walk_done = over || full || stop_q || (idx_q == '0);
        sts_o.fin_push  = 1'b1;
      end
      pas_pkg::OP_COMPLETE: begin
        sts_o.walk_done = (idx_q == cnt_q);
        sts_o.fin_push  = 1'b1;
      end
      pas_pkg::OP_SCAN: begin
        sts_o.walk_done = (idx_q == cnt_q) || (nres_q == RES_CAP_C);
        sts_o.fin_push  = held_v_q;
      end
      default: begin
        sts_o.walk_done = 1'b1;
        sts_o.fin_push  = 1'b0;
      end
    endcase
  end

  // Queue memory write port.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = rd_data;
    if (cmd_i.eval) begin
      case (op_q)
        pas_pkg::OP_SUBMIT: begin
          // Lower-priority entries move one place toward the tail.
          ram_we = !(rd_prio >= in_prio);
        end
        pas_pkg::OP_COMPLETE: begin
          ram_we    = found_q;
          ram_waddr = idx_m1[AW-1:0];
        end
        pas_pkg::OP_SCAN: begin
          ram_we    = sc_res;
          ram_wdata = upd_entry;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end else if (cmd_i.fin && (op_q == pas_pkg::OP_SUBMIT) && !over && !full) begin
      ram_we    = 1'b1;
      ram_wdata = new_entry;
    end
  end

  pas_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (rd_idx[AW-1:0]),
    .rdata_o (rd_data)
  );

  // Result beats and state updates.
  always_comb begin
    push      = 1'b0;
    push_st   = held_st_q;
    push_task = held_task_q;
    push_last = 1'b1;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    ntn_d     = ntn_q;
    found_d   = found_q;
    stop_d    = stop_q;
    nres_d    = nres_q;
    held_v_d  = held_v_q;
    for (int t = 0; t < NUM_TYPES; t++) begin
      run_d[t] = run_q[t];
    end

    if (cmd_i.accept) begin
      idx_d    = (pas_pkg::op_e'(in_op_i) == pas_pkg::OP_SUBMIT) ? cnt_q : '0;
      found_d  = 1'b0;
      stop_d   = 1'b0;
      nres_d   = '0;
      held_v_d = 1'b0;
    end else if (cmd_i.eval) begin
      case (op_q)
        pas_pkg::OP_SUBMIT: begin
          if (rd_prio >= in_prio) begin
            stop_d = 1'b1;
          end else begin
            idx_d = idx_m1;
          end
        end
        pas_pkg::OP_COMPLETE: begin
          if (!found_q && match) begin
            found_d = 1'b1;
            for (int t = 0; t < NUM_TYPES; t++) begin
              run_d[t] = (run_q[t] > {2'b00, rd_need[t]}) ?
                         (run_q[t] - {2'b00, rd_need[t]}) : '0;
            end
          end
          idx_d = idx_q + CW'(1);
        end
        pas_pkg::OP_SCAN: begin
          if (sc_disp) begin
            for (int t = 0; t < NUM_TYPES; t++) begin
              run_d[t] = run_q[t] + {2'b00, rd_need[t]};
            end
          end
          if (sc_res) begin
            // The previous result is now known not to be the last one.
            push      = held_v_q;
            push_last = 1'b0;
            held_v_d  = 1'b1;
            nres_d    = nres_q + XW'(1);
          end
          idx_d = idx_q + CW'(1);
        end
        default: begin
          idx_d = idx_q;
        end
      endcase
    end else if (cmd_i.fin) begin
      case (op_q)
        pas_pkg::OP_SUBMIT: begin
          push = 1'b1;
          if (over) begin
            push_st   = pas_pkg::ST_OVER_LIMIT;
            push_task = '0;
          end else if (full) begin
            push_st   = pas_pkg::ST_QUEUE_FULL;
            push_task = '0;
          end else begin
            push_st   = pas_pkg::ST_QUEUED;
            push_task = ntn_q;
            cnt_d     = cnt_q + CW'(1);
            ntn_d     = (ntn_q == TASK_MAX) ? TW'(1) : ntn_q + TW'(1);
          end
        end
        pas_pkg::OP_COMPLETE: begin
          push      = 1'b1;
          push_task = in_task;
          if (found_q) begin
            push_st = pas_pkg::ST_COMPLETED;
            cnt_d   = cnt_q - CW'(1);
          end else begin
            push_st = pas_pkg::ST_UNKNOWN;
          end
        end
        pas_pkg::OP_SCAN: begin
          push     = held_v_q;
          held_v_d = 1'b0;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      cnt_q       <= '0;
      ntn_q       <= TW'(1);
      found_q     <= 1'b0;
      stop_q      <= 1'b0;
      nres_q      <= '0;
      held_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int t = 0; t < NUM_TYPES; t++) begin
        run_q[t] <= '0;
        lim_q[t] <= LW'(1);
      end
    end else begin
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      ntn_q    <= ntn_d;
      found_q  <= found_d;
      stop_q   <= stop_d;
      nres_q   <= nres_d;
      held_v_q <= held_v_d;
      for (int t = 0; t < NUM_TYPES; t++) begin
        run_q[t] <= run_d[t];
        if (cfg_we_i && (cfg_idx_i == IW'(t))) begin
          lim_q[t] <= cfg_wdata_i;
        end
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= pas_pkg::op_e'(in_op_i);
      data_q <= in_data_i;
    end
    if (cmd_i.eval && (op_q == pas_pkg::OP_SCAN) && sc_res) begin
      held_st_q   <= sc_disp ? pas_pkg::ST_DISPATCHED : pas_pkg::ST_PENDING;
      held_task_q <= rd_task;
    end
    if (push) begin
      out_st_q   <= push_st;
      out_task_q <= push_task;
      out_last_q <= push_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_st_q;
  assign out_task_o   = out_task_q;
  assign out_last_o   = out_last_q;

  `PAS_NEVER(a_no_overwrite, push && out_valid_q && !out_ready_i, "result beat overwritten")
  `PAS_ASSERT(a_count_range, cnt_q <= DEPTH_C, "queue count beyond depth")
  `PAS_NEVER(a_task_zero, ntn_q == '0, "task number zero would be handed out")
  `PAS_ASSERT(a_result_cap, nres_q <= RES_CAP_C, "scan produced too many results")
  `PAS_ASSERT(a_read_in_queue, cmd_i.rd |-> (rd_idx < cnt_q), "read outside the queue")

endmodule

/* rtl/priority_admission_scheduler.sv */
// Priority admission scheduler top level: stream ports, controller and datapath.
//
// Each input beat is worked on alone; s_axis_tready_o is low from acceptance until the
// last result beat of that item has been handed to the output register. Every queue entry
// that an operation touches gets a read step and an evaluate step (S_WALK, S_EVAL) on the
// queue memory, which has one read and one write port, between the accept step and the
// finish step (S_FIN): a submit touches the entries compared against the new one (those
// that move behind it, plus the entry of equal or higher priority where the search stops,
// if there is one), a completion all queued entries, a scan the entries visited (at most
// the queue count, and the scan stops after sixteen results), and a rejected submit or an
// unused operation code touches none. A result beat that is not taken on m_axis holds the
// walk at that step. The queue memory needs no clearing after reset because only entries
// below the queue count are ever read.
module priority_admission_scheduler #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_TYPES   = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [pas_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pas_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  // Input stream.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: priority_req[3:0], need_type0..need_type6 [31:4], done_task[47:32]
  input  logic [pas_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  // tuser: operation[1:0]
  input  logic [pas_pkg::OP_W-1:0]      s_axis_tuser_i,
  // Result stream.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata: task_number[15:0]
  output logic [pas_pkg::TASK_W-1:0]    m_axis_tdata_o,
  // tuser: status[2:0]
  output logic [pas_pkg::STATUS_W-1:0]  m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);

  pas_pkg::pas_cmd_t cmd;
  pas_pkg::pas_sts_t sts;

  pas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pas_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_TYPES   (NUM_TYPES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_op_i      (s_axis_tuser_i),
    .in_data_i    (s_axis_tdata_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_task_o   (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule
